FILE: hw/rtl/hepd_pkg.sv
// ----------------------------------------------------------------------------
// Homography edge point decimator package
// Shared widths, reset values, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package hepd_pkg;

  // Default image width used by the right side margin test
  localparam int IMAGE_COLS_DEF = 320;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_PAIR  = 3'd0,
    REG_MIXED_PAIR = 3'd1,
    REG_ROW1_PAIR  = 3'd2,
    REG_ROW2_PAIR  = 3'd3,
    REG_COEF_LAST  = 3'd4,
    REG_MARGIN     = 3'd5,
    REG_SPACING    = 3'd6
  } cfg_idx_t;

  localparam logic [31:0] COEF_LAST_RESET = 32'h0010_0000;  // 1.0 in Q12.20
  localparam logic [15:0] SPACING_RESET   = 16'd14;

  // Datapath widths
  localparam int COEF_W   = 32;                 // Q12.20 coefficient
  localparam int MULB_W   = 18;                 // second multiplier operand
  localparam int MUL_W    = COEF_W + MULB_W;    // full product
  localparam int ACC_W    = 46;                 // u, v, w accumulators
  localparam int NUM_W    = ACC_W + 1;          // 2|n| + |w|
  localparam int QUO_W    = 16;                 // quotient bits kept
  localparam int SH_W     = NUM_W + QUO_W - 1;  // divisor shifted to the top bit
  localparam int DIST_W   = 34;                 // dx*dx + dy*dy
  localparam int MARGIN_W = 12;                 // signed margin compare
  localparam int CNT_W    = 4;

  localparam logic [CNT_W-1:0] MAC_LAST = 4'd6;
  localparam logic [CNT_W-1:0] DIV_LAST = 4'd15;
  localparam logic [CNT_W-1:0] SQR_LAST = 4'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_PREP,
    ST_DIV,
    ST_FIN,
    ST_SQR,
    ST_DECIDE
  } state_t;

endpackage

FILE: hw/rtl/homography_edge_point_decimator_top.sv
// ----------------------------------------------------------------------------
// Homography edge point decimator
// Maps side-tagged edge points through a 3x3 Q12.20 homography and keeps
// only points that are far enough from the side's last kept point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, fields side, first, px, py) takes one
//   point per transaction. Output channel (out_valid / out_stall, fields
//   out_side, out_x, out_y, degenerate) gives zero or one kept point per
//   input point, in order.
//   Configuration: cfg_we with cfg_index / cfg_data writes one register per
//   cycle; write only while the block is idle.
//   Datapath: one shared 32x18 multiplier and one shared restoring divider
//   stage run under a sequencer. A point goes from accept to the output
//   register through 7 multiply-accumulate steps, two divisions (each a
//   setup step, 16 quotient bits and a rounding/saturation step), 3 steps
//   for the squared distance and a decision step. A point with w equal
//   to zero skips both divisions. One point at a time; in_stall is high
//   while a point is in flight.
//   The output register holds one result, so the next point is accepted
//   while that result waits; a second result waits in the decision step
//   until the output register frees up.
//   Reset: control state, configuration registers and both sides' last
//   kept points go to their reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module homography_edge_point_decimator_top #(
  parameter int IMAGE_COLS = hepd_pkg::IMAGE_COLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_we,
  input  logic [hepd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hepd_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input points
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             side,
  input  logic                             first,
  input  logic [9:0]                       px,
  input  logic [9:0]                       py,
  // kept points
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_side,
  output logic signed [15:0]               out_x,
  output logic signed [15:0]               out_y,
  output logic                             degenerate
);

  import hepd_pkg::*;

  // Configuration registers
  logic [63:0] coef_row0_pair;
  logic [63:0] coef_mixed_pair;
  logic [63:0] coef_row1_pair;
  logic [63:0] coef_row2_pair;
  logic [31:0] coef_last;
  logic [7:0]  edge_margin;
  logic [15:0] min_spacing_sq;

  // Sequencer
  state_t           state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             sel;        // 0 while working on x, 1 on y

  // Latched point
  logic       pt_side;
  logic       pt_first;
  logic [9:0] pt_px;
  logic [9:0] pt_py;

  // Shared multiplier and accumulators
  logic signed [COEF_W-1:0] mul_a;
  logic signed [MULB_W-1:0] mul_b;
  logic signed [MUL_W-1:0]  prod;
  logic signed [ACC_W-1:0]  acc_u, acc_v, acc_w;
  logic signed [ACC_W-1:0]  acc_add;

  // Divider
  logic [NUM_W-1:0] rem;
  logic [SH_W-1:0]  dsh;
  logic [QUO_W-1:0] quo;
  logic             div_neg;
  logic             div_ge;
  logic signed [ACC_W-1:0] div_n;
  logic [ACC_W-1:0] abs_n, abs_w;
  logic             w_zero;
  logic signed [15:0] rnd;

  // Result and history
  logic signed [15:0] x, y;
  logic               degen;
  logic signed [15:0] last_x [2];
  logic signed [15:0] last_y [2];
  logic signed [16:0] dx, dy;
  logic [DIST_W-1:0]  dist_sq;

  // Decision
  logic                       margin_ok;
  logic signed [MARGIN_W-1:0] right_bound;
  logic signed [MARGIN_W-1:0] py_s;
  logic                       keep;
  logic                       out_free;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_row0_pair  <= '0;
      coef_mixed_pair <= '0;
      coef_row1_pair  <= '0;
      coef_row2_pair  <= '0;
      coef_last       <= COEF_LAST_RESET;
      edge_margin     <= '0;
      min_spacing_sq  <= SPACING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW0_PAIR:  coef_row0_pair  <= cfg_data;
        REG_MIXED_PAIR: coef_mixed_pair <= cfg_data;
        REG_ROW1_PAIR:  coef_row1_pair  <= cfg_data;
        REG_ROW2_PAIR:  coef_row2_pair  <= cfg_data;
        REG_COEF_LAST:  coef_last       <= cfg_data[31:0];
        REG_MARGIN:     edge_margin     <= cfg_data[7:0];
        REG_SPACING:    min_spacing_sq  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Divider step and operand conditioning
  assign div_n  = sel ? acc_v : acc_u;
  assign abs_n  = div_n[ACC_W-1] ? ACC_W'(-div_n) : ACC_W'(div_n);
  assign abs_w  = acc_w[ACC_W-1] ? ACC_W'(-acc_w) : ACC_W'(acc_w);
  assign w_zero = (acc_w == '0);
  assign div_ge = ({{(QUO_W-1){1'b0}}, rem} >= dsh);

  // Round half away from zero is built into the numerator; saturate here
  always_comb begin
    if (!div_neg) begin
      rnd = quo[QUO_W-1] ? 16'sh7FFF : signed'(quo);
    end else begin
      rnd = quo[QUO_W-1] ? 16'sh8000 : signed'(-quo);
    end
  end

  // Accumulator input for the current MAC step
  always_comb begin
    case (cnt)
      4'd1, 4'd2: acc_add = acc_u;
      4'd3, 4'd4: acc_add = acc_v;
      default:    acc_add = acc_w;
    endcase
  end

  // Distance to the side's last kept point
  assign dx = {x[15], x} - {last_x[pt_side][15], last_x[pt_side]};
  assign dy = {y[15], y} - {last_y[pt_side][15], last_y[pt_side]};

  // Margin and spacing decision
  assign right_bound = MARGIN_W'(IMAGE_COLS) - signed'({4'b0, edge_margin})
                       - MARGIN_W'(1);
  assign py_s        = signed'({2'b0, pt_py});
  assign margin_ok   = pt_side ? (py_s < right_bound)
                               : ({2'b0, pt_py} > {4'b0, edge_margin});
  assign keep        = pt_first
                       || (margin_ok && (dist_sq >= {{(DIST_W-16){1'b0}}, min_spacing_sq}));
  assign out_free    = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_MAC;
      ST_MAC:    if (cnt == MAC_LAST) state_next = ST_PREP;
      ST_PREP:   state_next = w_zero ? ST_SQR : ST_DIV;
      ST_DIV:    if (cnt == DIV_LAST) state_next = ST_FIN;
      ST_FIN:    state_next = sel ? ST_SQR : ST_PREP;
      ST_SQR:    if (cnt == SQR_LAST) state_next = ST_DECIDE;
      ST_DECIDE: if (!keep || out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and multiplier operand select
  always_comb begin
    in_stall = (state != ST_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    case (state)
      ST_MAC: begin
        case (cnt)
          4'd0: begin mul_a = signed'(coef_row0_pair[31:0]);  mul_b = signed'({8'b0, pt_py}); end
          4'd1: begin mul_a = signed'(coef_row0_pair[63:32]); mul_b = signed'({8'b0, pt_px}); end
          4'd2: begin mul_a = signed'(coef_mixed_pair[63:32]); mul_b = signed'({8'b0, pt_py}); end
          4'd3: begin mul_a = signed'(coef_row1_pair[31:0]);  mul_b = signed'({8'b0, pt_px}); end
          4'd4: begin mul_a = signed'(coef_row2_pair[31:0]);  mul_b = signed'({8'b0, pt_py}); end
          4'd5: begin mul_a = signed'(coef_row2_pair[63:32]); mul_b = signed'({8'b0, pt_px}); end
          default: ;
        endcase
      end
      ST_SQR: begin
        if (cnt == '0) begin
          mul_a = COEF_W'(dx);
          mul_b = MULB_W'(dx);
        end else begin
          mul_a = COEF_W'(dy);
          mul_b = MULB_W'(dy);
        end
      end
      default: ;
    endcase
  end

  // State register, output valid and last kept points
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      last_x[0] <= '0;
      last_x[1] <= '0;
      last_y[0] <= '0;
      last_y[1] <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DECIDE && keep && out_free) begin
        out_valid       <= 1'b1;
        last_x[pt_side] <= x;
        last_y[pt_side] <= y;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (state == ST_DECIDE && keep && out_free) begin
      out_side   <= pt_side;
      out_x      <= x;
      out_y      <= y;
      degenerate <= degen;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        pt_side  <= side;
        pt_first <= first;
        pt_px    <= px;
        pt_py    <= py;
        acc_u    <= ACC_W'(signed'(coef_mixed_pair[31:0]));
        acc_v    <= ACC_W'(signed'(coef_row1_pair[63:32]));
        acc_w    <= ACC_W'(signed'(coef_last));
        cnt      <= '0;
        sel      <= 1'b0;
        degen    <= 1'b0;
      end
      // one product per cycle, accumulated in the following cycle
      ST_MAC: begin
        prod <= mul_a * mul_b;
        if (cnt != '0) begin
          case (cnt)
            4'd1, 4'd2: acc_u <= acc_add + ACC_W'(prod);
            4'd3, 4'd4: acc_v <= acc_add + ACC_W'(prod);
            default:    acc_w <= acc_add + ACC_W'(prod);
          endcase
        end
        cnt <= (cnt == MAC_LAST) ? '0 : cnt + CNT_W'(1);
      end
      // numerator 2|n|+|w|, divisor 2|w| aligned to the top quotient bit
      ST_PREP: begin
        rem     <= {abs_n, 1'b0} + {1'b0, abs_w};
        dsh     <= {abs_w, 1'b0, {(QUO_W-1){1'b0}}};
        div_neg <= div_n[ACC_W-1] ^ acc_w[ACC_W-1];
        quo     <= '0;
        cnt     <= '0;
        if (w_zero) begin
          x     <= -16'sd1;
          y     <= -16'sd1;
          degen <= 1'b1;
        end
      end
      // restoring division, one quotient bit per cycle
      ST_DIV: begin
        if (div_ge) rem <= rem - dsh[NUM_W-1:0];
        quo <= {quo[QUO_W-2:0], div_ge};
        dsh <= dsh >> 1;
        cnt <= cnt + CNT_W'(1);
      end
      ST_FIN: begin
        if (sel) y <= rnd;
        else     x <= rnd;
        sel <= 1'b1;
        cnt <= '0;
      end
      // dx*dx then dy*dy through the shared multiplier
      ST_SQR: begin
        prod <= mul_a * mul_b;
        if (cnt == 4'd1) dist_sq <= DIST_W'(prod);
        if (cnt == SQR_LAST) dist_sq <= dist_sq + DIST_W'(prod);
        cnt <= cnt + CNT_W'(1);
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/hepd_checker.sv
// ----------------------------------------------------------------------------
// Homography edge point decimator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module hepd_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_side,
  input logic signed [15:0] out_x,
  input logic signed [15:0] out_y,
  input logic              degenerate
);

  // A result waiting under stall keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_side) && $stable(degenerate))
    else $error("stalled result changed");

  // An accepted point blocks the input channel while it is worked on
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while busy");

  // A new result only comes out of a busy sequencer
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a point in flight");

  // Zero w maps to (-1,-1)
  assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> out_x == -16'sd1 && out_y == -16'sd1)
    else $error("degenerate result not (-1,-1)");

endmodule

bind homography_edge_point_decimator_top hepd_checker u_hepd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_side   (out_side),
  .out_x      (out_x),
  .out_y      (out_y),
  .degenerate (degenerate)
);

FILE: bench/tb_homography_edge_point_decimator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Homography edge point decimator testbench
// Feeds side-tagged edge points through several homography and thinning
// settings, predicts every kept point in the bench and checks each output
// transaction field by field, in order, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_homography_edge_point_decimator_top;
  import hepd_pkg::*;

  localparam int COLS           = IMAGE_COLS_DEF;
  localparam int SETTLE_CYCLES  = 80;    // one full point plus output register
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
  localparam int MAX_REPORTS    = 40;

  localparam logic [31:0] ONE_Q       = 32'h0010_0000;  // 1.0 in Q12.20
  localparam logic [31:0] MINUS_ONE_Q = 32'hFFF0_0000;  // -1.0 in Q12.20
  localparam logic [31:0] TWO_Q       = 32'h0020_0000;  // 2.0 in Q12.20

  typedef struct packed {
    logic       side;
    logic       first;
    logic [9:0] px;
    logic [9:0] py;
  } edge_pt_t;

  typedef struct packed {
    logic               side;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               degen;
  } kept_pt_t;

  // DUT ports, inputs known from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  side = 1'b0;
  logic                  first = 1'b0;
  logic [9:0]            px = '0;
  logic [9:0]            py = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_side;
  logic signed [15:0]    out_x;
  logic signed [15:0]    out_y;
  logic                  degenerate;

  // Bench copy of configuration and per-side state
  logic [63:0]        cfg_row0 = '0;
  logic [63:0]        cfg_mixed = '0;
  logic [63:0]        cfg_row1 = '0;
  logic [63:0]        cfg_row2 = '0;
  logic [31:0]        cfg_h22 = COEF_LAST_RESET;
  logic [7:0]         cfg_margin = '0;
  logic [15:0]        cfg_spacing = SPACING_RESET;
  logic signed [15:0] last_x [2] = '{16'sd0, 16'sd0};
  logic signed [15:0] last_y [2] = '{16'sd0, 16'sd0};

  edge_pt_t pending_pts [$];
  kept_pt_t kept_points_due [$];
  edge_pt_t cur_pt;
  kept_pt_t predicted;
  kept_pt_t want;
  bit       quiet = 1'b0;
  int       gap_left = 0;
  int       stall_left = 0;
  int       idle_cycles = 0;
  int       n_mismatches = 0;

  homography_edge_point_decimator_top #(
    .IMAGE_COLS(COLS)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .side       (side),
    .first      (first),
    .px         (px),
    .py         (py),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_side   (out_side),
    .out_x      (out_x),
    .out_y      (out_y),
    .degenerate (degenerate)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // n / d rounded half away from zero, clamped to 16 bits; d is nonzero
  function automatic logic signed [15:0] rounded_quotient(longint n, longint d);
    longint unsigned an, ad, q;
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    q  = (2 * an + ad) / (2 * ad);
    if ((n < 0) != (d < 0))
      return (q > 64'd32768) ? 16'sh8000 : 16'(-q);
    return (q > 64'd32767) ? 16'sh7fff : 16'(q);
  endfunction

  // Maps one point and applies the side's margin and spacing tests.
  // Returns 1 and the kept point when it survives; updates the side state.
  function automatic bit map_and_thin(input edge_pt_t pt, output kept_pt_t kp);
    longint h00, h01, h02, h10, h11, h12, h20, h21, h22;
    longint fx, fy, u, v, w, dx, dy, dist_sq;
    logic signed [15:0] x, y;
    int bound;
    bit pass;
    h00 = $signed(cfg_row0[31:0]);
    h01 = $signed(cfg_row0[63:32]);
    h02 = $signed(cfg_mixed[31:0]);
    h10 = $signed(cfg_mixed[63:32]);
    h11 = $signed(cfg_row1[31:0]);
    h12 = $signed(cfg_row1[63:32]);
    h20 = $signed(cfg_row2[31:0]);
    h21 = $signed(cfg_row2[63:32]);
    h22 = $signed(cfg_h22);
    fx = pt.px;
    fy = pt.py;
    // source vector is (py, px, 1)
    u = h00 * fy + h01 * fx + h02;
    v = h10 * fy + h11 * fx + h12;
    w = h20 * fy + h21 * fx + h22;
    if (w == 0) begin
      x = -16'sd1;
      y = -16'sd1;
    end else begin
      x = rounded_quotient(u, w);
      y = rounded_quotient(v, w);
    end
    if (pt.first) begin
      pass = 1'b1;
    end else begin
      dx      = x - last_x[pt.side];
      dy      = y - last_y[pt.side];
      dist_sq = dx * dx + dy * dy;
      if (!pt.side) begin
        pass = fy > cfg_margin;
      end else begin
        bound = COLS - int'(cfg_margin) - 1;
        pass  = fy < bound;
      end
      pass = pass && (dist_sq >= cfg_spacing);
    end
    kp.side  = pt.side;
    kp.x     = x;
    kp.y     = y;
    kp.degen = (w == 0);
    if (pass) begin
      last_x[pt.side] = x;
      last_y[pt.side] = y;
    end
    return pass;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mostly no idling, some short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(99, 0);
    if (quiet || r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic int clamp10(int val);
    if (val < 0)
      return 0;
    if (val > 1023)
      return 1023;
    return val;
  endfunction

  // Random signed coefficient in [-span, span]
  function automatic logic [31:0] rand_q(int unsigned span);
    return 32'(int'($urandom_range(2 * span, 0)) - int'(span));
  endfunction

  function automatic void add_point(logic s, logic f, logic [9:0] x, logic [9:0] y);
    edge_pt_t pt;
    pt.side  = s;
    pt.first = f;
    pt.px    = x;
    pt.py    = y;
    pending_pts = {pending_pts, pt};
  endfunction

  // Edge lists: a first-marked point followed by a short walk, with some
  // stray points and a few misplaced first marks mixed in
  task automatic queue_edge_runs(int count);
    int  cx, cy, run_len;
    logic s;
    while (count > 0) begin
      s = 1'($urandom_range(1, 0));
      if ($urandom_range(9, 0) == 0) begin
        add_point(s, ($urandom_range(3, 0) == 0), 10'($urandom), 10'($urandom));
        count--;
      end else begin
        cx = $urandom_range(1023, 0);
        cy = $urandom_range(1023, 0);
        add_point(s, 1'b1, cx[9:0], cy[9:0]);
        count--;
        run_len = $urandom_range(16, 2);
        for (int k = 0; k < run_len && count > 0; k++) begin
          cx = clamp10(cx + int'($urandom_range(6, 0)) - 3);
          cy = clamp10(cy + int'($urandom_range(4, 0)));
          add_point(s, ($urandom_range(19, 0) == 0), cx[9:0], cy[9:0]);
          count--;
        end
      end
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_ROW0_PAIR:  cfg_row0    = data;
      REG_MIXED_PAIR: cfg_mixed   = data;
      REG_ROW1_PAIR:  cfg_row1    = data;
      REG_ROW2_PAIR:  cfg_row2    = data;
      REG_COEF_LAST:  cfg_h22     = data[31:0];
      REG_MARGIN:     cfg_margin  = data[7:0];
      REG_SPACING:    cfg_spacing = data[15:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [63:0] r0, r1, r2, r3,
                             input logic [31:0] h22_val,
                             input logic [7:0] margin_val,
                             input logic [15:0] spacing_val);
    write_reg(REG_ROW0_PAIR, r0);
    write_reg(REG_MIXED_PAIR, r1);
    write_reg(REG_ROW1_PAIR, r2);
    write_reg(REG_ROW2_PAIR, r3);
    write_reg(REG_COEF_LAST, {32'h0, h22_val});
    write_reg(REG_MARGIN, {56'h0, margin_val});
    write_reg(REG_SPACING, {48'h0, spacing_val});
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every point is in and every kept point is out, then let
  // a dropped point still in flight finish
  task automatic wait_idle();
    @(negedge clk);
    while (pending_pts.size() != 0 || in_valid || kept_points_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic report_mismatch(string msg);
    n_mismatches++;
    if (n_mismatches <= MAX_REPORTS)
      $display("%0t ERROR %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Input driver: one point per transaction, held while stalled
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (map_and_thin(cur_pt, predicted))
          kept_points_due = {kept_points_due, predicted};
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending_pts.size() != 0) begin
          cur_pt = pending_pts.pop_front();
          side     <= cur_pt.side;
          first    <= cur_pt.first;
          px       <= cur_pt.px;
          py       <= cur_pt.py;
          in_valid <= 1'b1;
          gap_left = idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: random stalls, in-order check of kept points
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (kept_points_due.size() == 0) begin
          report_mismatch($sformatf("unexpected point side=%0d x=%0d y=%0d",
                                    out_side, out_x, out_y));
        end else begin
          want = kept_points_due.pop_front();
          if (out_side !== want.side)
            report_mismatch($sformatf("out_side got %0d expected %0d",
                                      out_side, want.side));
          if (out_x !== want.x)
            report_mismatch($sformatf("out_x got %0d expected %0d", out_x, want.x));
          if (out_y !== want.y)
            report_mismatch($sformatf("out_y got %0d expected %0d", out_y, want.y));
          if (degenerate !== want.degen)
            report_mismatch($sformatf("degenerate got %0d expected %0d",
                                      degenerate, want.degen));
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(7, 0) == 0)
          stall_left = idle_len();
      end
    end
  end

  // Watchdog: no transaction on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: everything maps to the origin
    add_point(1'b0, 1'b0, 10'd0, 10'd0);        // no first mark yet, too close
    add_point(1'b1, 1'b0, 10'd1023, 10'd1023);  // right margin fails
    add_point(1'b0, 1'b1, 10'd1023, 10'd0);
    add_point(1'b1, 1'b1, 10'd0, 10'd1023);
    wait_idle();

    // Swap mapping x = px, y = py; spacing and margin edges
    load_config({ONE_Q, 32'h0}, {ONE_Q, 32'h0}, 64'h0, 64'h0, ONE_Q, 8'd0, 16'd14);
    add_point(1'b0, 1'b0, 10'd3, 10'd2);        // distance 13 from origin
    add_point(1'b0, 1'b0, 10'd3, 10'd3);        // distance 18
    add_point(1'b0, 1'b0, 10'd10, 10'd0);       // left margin fails
    add_point(1'b1, 1'b0, 10'd0, 10'd319);      // right margin fails at bound
    add_point(1'b1, 1'b0, 10'd0, 10'd318);
    add_point(1'b1, 1'b0, 10'd1023, 10'd1023);
    add_point(1'b0, 1'b1, 10'd1023, 10'd1023);
    add_point(1'b0, 1'b0, 10'd1023, 10'd1023);  // zero distance
    add_point(1'b0, 1'b0, 10'd1023, 10'd1019);  // distance 16
    queue_edge_runs(120);
    wait_idle();

    // w = py - px: zero w, widest margin, zero spacing
    load_config({ONE_Q, 32'h0}, {ONE_Q, 32'h0}, 64'h0, {MINUS_ONE_Q, ONE_Q},
                32'h0, 8'd255, 16'd0);
    add_point(1'b0, 1'b1, 10'd5, 10'd5);
    add_point(1'b0, 1'b0, 10'd7, 10'd7);
    add_point(1'b0, 1'b0, 10'd300, 10'd300);
    add_point(1'b1, 1'b0, 10'd40, 10'd40);
    add_point(1'b1, 1'b0, 10'd64, 10'd63);
    add_point(1'b1, 1'b0, 10'd10, 10'd64);
    queue_edge_runs(70);
    wait_idle();

    // Tiny w and extreme coefficients: saturation both ways, widest spacing
    load_config({32'h8000_0000, 32'h7FFF_FFFF}, {ONE_Q, 32'hFFFF_FFFF},
                {32'h0, MINUS_ONE_Q}, 64'h0, 32'h1, 8'd0, 16'hFFFF);
    add_point(1'b0, 1'b1, 10'd0, 10'd0);
    add_point(1'b0, 1'b0, 10'd1023, 10'd0);
    add_point(1'b0, 1'b0, 10'd0, 10'd1023);
    add_point(1'b1, 1'b1, 10'd5, 10'd5);
    add_point(1'b1, 1'b0, 10'd6, 10'd5);
    queue_edge_runs(50);
    wait_idle();

    // Halves: rounding away from zero on both signs, no idling
    quiet = 1'b1;
    load_config({MINUS_ONE_Q, 32'h0}, {ONE_Q, 32'h0}, 64'h0, 64'h0,
                TWO_Q, 8'd0, 16'd1);
    add_point(1'b0, 1'b1, 10'd3, 10'd5);
    add_point(1'b0, 1'b0, 10'd1, 10'd1);
    queue_edge_runs(80);
    wait_idle();
    quiet = 1'b0;

    // Random perspective mappings
    repeat (2) begin
      load_config({rand_q(2 * ONE_Q), rand_q(2 * ONE_Q)},
                  {rand_q(2 * ONE_Q), rand_q(300 * ONE_Q)},
                  {rand_q(300 * ONE_Q), rand_q(2 * ONE_Q)},
                  {rand_q(2048), rand_q(2048)},
                  ONE_Q + rand_q(ONE_Q / 4),
                  8'($urandom_range(255, 0)), 16'($urandom_range(200, 0)));
      queue_edge_runs(65);
      wait_idle();
    end

    // All coefficient bits set: every point maps to (1,1)
    quiet = 1'b1;
    load_config('1, '1, '1, '1, '1, 8'd3, 16'd0);
    queue_edge_runs(30);
    wait_idle();
    quiet = 1'b0;

    // Fully random registers
    load_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, $urandom, 8'($urandom), 16'($urandom));
    queue_edge_runs(50);
    wait_idle();

    if (n_mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: homography_edge_point_decimator_top.f
hw/rtl/hepd_pkg.sv
hw/rtl/homography_edge_point_decimator_top.sv
hw/rtl/hepd_checker.sv
bench/tb_homography_edge_point_decimator_top.sv
